// ----- rtl/core/medf_pkg.sv -----
// medf_pkg: shared types and constants of the rank-4 window filter
// depends on nothing; used by median_filter_3x3_3x2_top
`timescale 1ns / 1ps
`default_nettype none

package medf_pkg;

  // defaults handed to the top-level parameters
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int PIXEL_BITS_DEF = 16;

  // fixed field widths on the ports
  localparam int PIX_W      = 16;
  localparam int COL_W      = 12;
  localparam int ROW_W      = 16;
  localparam int IMG_W_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // smallest usable frame dimension and first column with a full window
  localparam int MIN_DIM        = 3;
  localparam int FIRST_FULL_COL = 2;

  // results one item may cause, and depth of the result queue
  localparam int MAX_RES     = 3;
  localparam int QUEUE_DEPTH = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_idx_t REG_WINDOW_MODE  = 2'd2;

  localparam logic MODE_3X3 = 1'b0;
  localparam logic MODE_3X2 = 1'b1;

  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 13'd512;
  localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd512;

  // one result item as it sits in the queue
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/median_filter_3x3_3x2_top.sv -----
// median_filter_3x3_3x2_top: streaming rank-4 filter over a 3x3 or 3x2 window
// depends on medf_pkg for field widths, register codes and the result type
`timescale 1ns / 1ps
`default_nettype none

// Streaming rank-4 (fifth smallest) filter for raster-order pixels. One input
// item can be taken every clock while in_ready is high: it is registered with
// its position and the line store read, its window is assembled and each
// column sorted in the next cycle, and the cycle after that the median of
// nine is formed and its up to three result items go into a 16-entry result
// queue. Results leave one per clock while out_ready is high. in_ready drops
// only when the queue cannot hold three results for every item still in the
// pipeline plus the next one. In 3x3 mode a filtered row comes out while the
// row below it arrives; rows 0 and H-1 are copied, columns 0 and W-1 repeat
// their neighbour. In 3x2 mode (row above and current row) results carry no
// row delay and the edge rows and columns are copied. With width three in 3x3
// mode the copy of a frame's final pixel is held back and delivered first with
// the next item. The line stores are one memory of MAX_WIDTH words holding
// rows r-2 and r-1 side by side; it is not cleared after reset, which is
// harmless because a frame never uses a store entry it has not written.
// Configuration (width, height, mode) is to be written by the user only while
// the block is idle; the block itself does not enforce this. cfg_ready is
// always high.
module median_filter_3x3_3x2_top #(
  parameter int MAX_WIDTH  = medf_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = medf_pkg::PIXEL_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // input pixel channel
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [medf_pkg::PIX_W-1:0]         in_pixel_in,
  // result channel
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [medf_pkg::PIX_W-1:0]         out_pixel_out,
  output logic [medf_pkg::COL_W-1:0]         out_column,
  output logic [medf_pkg::ROW_W-1:0]         out_row,
  output logic                               out_last_of_run,
  // configuration write channel
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [medf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [medf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // widths derived from the parameters
  localparam int PB     = PIXEL_BITS;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W  = (WW > medf_pkg::IMG_W_W) ? WW : medf_pkg::IMG_W_W;
  localparam int OPW    = medf_pkg::PIX_W;
  localparam int OCW    = medf_pkg::COL_W;
  localparam int ORW    = medf_pkg::ROW_W;
  localparam int NRES   = medf_pkg::MAX_RES;
  localparam int QD     = medf_pkg::QUEUE_DEPTH;
  localparam int QA     = $clog2(QD);
  localparam int RSV_W  = $clog2(QD + 3 * NRES) + 1;
  localparam int NCAND  = 5;

  localparam logic [CMP_W-1:0] MAXW_C  = CMP_W'(MAX_WIDTH);
  localparam logic [CMP_W-1:0] MINW_C  = CMP_W'(medf_pkg::MIN_DIM);
  localparam logic [CMP_W-1:0] FULL_C  = CMP_W'(medf_pkg::FIRST_FULL_COL);
  localparam logic [ORW-1:0]   MINH_C  = ORW'(medf_pkg::MIN_DIM);
  localparam logic [ORW-1:0]   FULLR_C = ORW'(medf_pkg::FIRST_FULL_COL);

  typedef logic [PB-1:0] pix_t;
  typedef pix_t [2:0]    trip_t;   // [0] low, [1] middle, [2] high

  // per-item control carried down the pipeline
  typedef struct packed {
    pix_t           pix;
    logic [OCW-1:0] col;
    logic [OCW-1:0] c_m1;
    logic [OCW-1:0] wm1;
    logic [ORW-1:0] row;
    logic [ORW-1:0] row_m1;
    logic           c_is0;
    logic           c_is2;
    logic           c_ge2;
    logic           c_last;
    logic           r_edge;
    logic           r_ge2;
  } ctl_t;

  function automatic pix_t pmin(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t pmax(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t x);
    return pmax(pmin(a, b), pmin(pmax(a, b), x));
  endfunction

  function automatic trip_t sort3(input pix_t a, input pix_t b, input pix_t x);
    trip_t t;
    pix_t  lo1;
    pix_t  hi1;
    pix_t  up;
    lo1  = pmin(a, b);
    hi1  = pmax(a, b);
    up   = pmax(lo1, x);
    t[0] = pmin(lo1, x);
    t[1] = pmin(hi1, up);
    t[2] = pmax(hi1, up);
    return t;
  endfunction

  // configuration registers
  logic [medf_pkg::IMG_W_W-1:0] img_width_r;
  logic [ORW-1:0]               img_height_r;
  logic                         win_mode_r;

  // position of the next input item
  logic [CW-1:0]  col_r, col_nxt;
  logic [ORW-1:0] row_r, row_nxt;

  // line stores: {row r-2, row r-1} per column
  logic [2*PB-1:0] line_mem [MAX_WIDTH];
  logic [2*PB-1:0] rd_data_r;

  // window: columns c-2 (0..2) and c-1 (3..5), rows r-2, r-1, r
  pix_t win_r [6];

  // pipeline stages
  logic           s1_v_r, s2_v_r;
  ctl_t           s1_ctl_r, s2_ctl_r;
  logic [CW-1:0]  s1_addr_r;
  trip_t          s2_trip_r [3];

  // deferred copy of a frame's final pixel
  logic                  held_v_r, held_v_nxt;
  medf_pkg::res_t        held_r;

  // result queue
  medf_pkg::res_t q_mem_r [QD];
  logic [QA-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QA:0]    cnt_r;

  logic in_fire, out_fire;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= medf_pkg::WIDTH_RESET;
      img_height_r <= medf_pkg::HEIGHT_RESET;
      win_mode_r   <= medf_pkg::MODE_3X3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        medf_pkg::REG_IMAGE_WIDTH:  img_width_r  <= cfg_data[medf_pkg::IMG_W_W-1:0];
        medf_pkg::REG_IMAGE_HEIGHT: img_height_r <= cfg_data[ORW-1:0];
        medf_pkg::REG_WINDOW_MODE:  win_mode_r   <= cfg_data[0];
        default: ;   // unknown register index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // accept stage: clamp the frame size, place the item, read line stores
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0] width_ext, w_eff, c_ext, c_inc;
  logic [ORW-1:0]   h_eff, r_pre, r0, r_inc;
  logic [CW-1:0]    c0;
  ctl_t             ctl0;

  always_comb begin
    width_ext = CMP_W'(img_width_r);
    if (width_ext < MINW_C) begin
      w_eff = MINW_C;
    end else if (width_ext > MAXW_C) begin
      w_eff = MAXW_C;
    end else begin
      w_eff = width_ext;
    end
    h_eff = (img_height_r < MINH_C) ? MINH_C : img_height_r;

    // stale position after a smaller frame was set
    if (CMP_W'(col_r) >= w_eff) begin
      c0    = '0;
      r_pre = row_r + 1'b1;
    end else begin
      c0    = col_r;
      r_pre = row_r;
    end
    r0    = (r_pre >= h_eff) ? '0 : r_pre;
    c_ext = CMP_W'(c0);

    // position of the following item
    c_inc = c_ext + 1'b1;
    r_inc = r0 + 1'b1;
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h_eff) ? '0 : r_inc;
    end else begin
      col_nxt = CW'(c_inc);
      row_nxt = r0;
    end

    ctl0.pix    = in_pixel_in[PB-1:0];
    ctl0.col    = OCW'(c0);
    ctl0.c_m1   = OCW'(c0) - 1'b1;
    ctl0.wm1    = OCW'(w_eff - 1'b1);
    ctl0.row    = r0;
    ctl0.row_m1 = r0 - 1'b1;
    ctl0.c_is0  = (c_ext == '0);
    ctl0.c_is2  = (c_ext == FULL_C);
    ctl0.c_ge2  = (c_ext >= FULL_C);
    ctl0.c_last = (c_ext == w_eff - 1'b1);
    ctl0.r_edge = (r0 == '0) || (r0 == h_eff - 1'b1);
    ctl0.r_ge2  = (r0 >= FULLR_C);
  end

  // reserve room for the worst case of every item in flight plus this one
  logic [1:0]       n_flight;
  logic [RSV_W-1:0] need;

  always_comb begin
    n_flight = 2'(s1_v_r) + 2'(s2_v_r);
    need     = RSV_W'(cnt_r) + RSV_W'(NRES) * (RSV_W'(n_flight) + 1'b1);
    in_ready = (need <= RSV_W'(QD));
  end

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_fire;
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ctl_r  <= ctl0;
      s1_addr_r <= c0;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: line store data in, window assembled, columns sorted
  // ---------------------------------------------------------------------
  pix_t  up2, up1;
  trip_t trip1 [3];

  assign up2 = rd_data_r[2*PB-1:PB];
  assign up1 = rd_data_r[PB-1:0];

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      line_mem[s1_addr_r] <= {up1, s1_ctl_r.pix};
    end
    if (in_fire) begin
      rd_data_r <= line_mem[c0];
    end
  end

  always_comb begin
    if (win_mode_r == medf_pkg::MODE_3X3) begin
      trip1[0] = sort3(win_r[0], win_r[1], win_r[2]);
      trip1[1] = sort3(win_r[3], win_r[4], win_r[5]);
      trip1[2] = sort3(up2, up1, s1_ctl_r.pix);
    end else begin
      // six pixels padded with three of full scale keep rank 4 in place
      trip1[0] = sort3(win_r[1], win_r[2], win_r[4]);
      trip1[1] = sort3(win_r[5], up1, s1_ctl_r.pix);
      trip1[2] = {3{{PB{1'b1}}}};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      win_r[0]     <= win_r[3];
      win_r[1]     <= win_r[4];
      win_r[2]     <= win_r[5];
      win_r[3]     <= up2;
      win_r[4]     <= up1;
      win_r[5]     <= s1_ctl_r.pix;
      s2_ctl_r     <= s1_ctl_r;
      s2_trip_r[0] <= trip1[0];
      s2_trip_r[1] <= trip1[1];
      s2_trip_r[2] <= trip1[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: median of nine, result items listed in output order
  // ---------------------------------------------------------------------
  pix_t             lo_max, mid_med, hi_min, med;
  logic [OPW-1:0]   med_w, pix_w;
  medf_pkg::res_t   cand [NCAND];
  logic [NCAND-1:0] cand_en;
  medf_pkg::res_t   res [NRES];
  logic [2:0]       n_res;
  logic             hold_set;
  logic             mode_33;

  always_comb begin
    lo_max  = pmax(pmax(s2_trip_r[0][0], s2_trip_r[1][0]), s2_trip_r[2][0]);
    mid_med = med3(s2_trip_r[0][1], s2_trip_r[1][1], s2_trip_r[2][1]);
    hi_min  = pmin(pmin(s2_trip_r[0][2], s2_trip_r[1][2]), s2_trip_r[2][2]);
    med     = med3(lo_max, mid_med, hi_min);
    med_w   = OPW'(med);
    pix_w   = OPW'(s2_ctl_r.pix);
    mode_33 = (win_mode_r == medf_pkg::MODE_3X3);

    // held copy from the previous frame goes first
    cand[0]    = held_r;
    cand_en[0] = held_v_r;

    // first column: filtered value (3x3) or copy (3x2)
    cand[1].pix  = mode_33 ? med_w : pix_w;
    cand[1].col  = '0;
    cand[1].row  = mode_33 ? s2_ctl_r.row_m1 : s2_ctl_r.row;
    cand[1].last = 1'b0;
    cand_en[1]   = mode_33 ? (s2_ctl_r.r_ge2 && s2_ctl_r.c_is2)
                           : (!s2_ctl_r.r_edge && s2_ctl_r.c_is0);

    // filtered centre column
    cand[2].pix  = med_w;
    cand[2].col  = s2_ctl_r.c_m1;
    cand[2].row  = mode_33 ? s2_ctl_r.row_m1 : s2_ctl_r.row;
    cand[2].last = 1'b0;
    cand_en[2]   = s2_ctl_r.c_ge2 && (mode_33 ? s2_ctl_r.r_ge2 : !s2_ctl_r.r_edge);

    // last column: filtered value (3x3) or copy (3x2)
    cand[3].pix  = mode_33 ? med_w : pix_w;
    cand[3].col  = s2_ctl_r.wm1;
    cand[3].row  = mode_33 ? s2_ctl_r.row_m1 : s2_ctl_r.row;
    cand[3].last = 1'b0;
    cand_en[3]   = s2_ctl_r.c_last && (mode_33 ? (s2_ctl_r.r_ge2 && s2_ctl_r.c_ge2)
                                               : !s2_ctl_r.r_edge);

    // top and bottom rows copied
    cand[4].pix  = pix_w;
    cand[4].col  = s2_ctl_r.col;
    cand[4].row  = s2_ctl_r.row;
    cand[4].last = 1'b0;
    cand_en[4]   = s2_ctl_r.r_edge;

    // pack enabled candidates; a copy that finds the list full is held back
    n_res    = '0;
    hold_set = 1'b0;
    for (int k = 0; k < NCAND; k++) begin
      res[k % NRES] = res[k % NRES];
    end
    for (int i = 0; i < NRES; i++) begin
      res[i] = cand[4];
    end
    for (int k = 0; k < NCAND; k++) begin
      if (cand_en[k]) begin
        if (n_res < 3'(NRES)) begin
          res[n_res[1:0]] = cand[k];
          n_res           = n_res + 1'b1;
        end else if (k == NCAND - 1) begin
          hold_set = 1'b1;
        end
      end
    end
    if (n_res != '0) begin
      res[2'(n_res - 1'b1)].last = 1'b1;
    end

    held_v_nxt = held_v_r;
    if (s2_v_r) begin
      held_v_nxt = hold_set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r <= 1'b0;
    end else begin
      held_v_r <= held_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && hold_set) begin
      held_r <= cand[4];
    end
  end

  // ---------------------------------------------------------------------
  // result queue: up to three in per clock, one out
  // ---------------------------------------------------------------------
  logic [2:0]    n_push;
  logic [QA-1:0] wr_ptr_nxt, rd_ptr_nxt;
  logic [QA:0]   cnt_nxt;

  assign out_valid = (cnt_r != '0);
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    n_push     = s2_v_r ? n_res : '0;
    wr_ptr_nxt = wr_ptr_r + QA'(n_push);
    rd_ptr_nxt = rd_ptr_r + QA'(out_fire);
    cnt_nxt    = cnt_r + (QA+1)'(n_push) - (QA+1)'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NRES; i++) begin
      if (3'(i) < n_push) begin
        q_mem_r[wr_ptr_r + QA'(i)] <= res[i];
      end
    end
  end

  medf_pkg::res_t head;

  assign head            = q_mem_r[rd_ptr_r];
  assign out_pixel_out   = head.pix;
  assign out_column      = head.col;
  assign out_row         = head.row;
  assign out_last_of_run = head.last;

endmodule

`default_nettype wire

// ----- dv/tb_median_filter_3x3_3x2_top.sv -----
// testbench for median_filter_3x3_3x2_top: streams raster frames through the filter and
// checks every result item against a predictor of the rank-4 window filter
// depends on medf_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb_median_filter_3x3_3x2_top;
  import medf_pkg::*;

  localparam int MAX_W          = MAX_WIDTH_DEF;
  localparam int SETTLE_CYCLES  = 12;       // pipeline plus queue, generous
  localparam int CYCLE_LIMIT    = 400_000;
  localparam int MAX_REPORTS    = 20;

  // index with no register behind it, writes to it must be ignored
  localparam cfg_idx_t REG_SPARE = 2'd3;

  typedef enum {PX_FULL, PX_BAND, PX_EXTREME} px_style_e;

  // clock and reset
  logic clk;
  logic rst_n = 1'b0;

  // dut ports
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_pixel_out;
  logic [COL_W-1:0]      out_column;
  logic [ROW_W-1:0]      out_row;
  logic                  out_last_of_run;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the registers, reset values
  int unsigned px_width  = 512;
  int unsigned px_height = 512;
  logic        px_mode   = MODE_3X3;

  // predictor copy of the line stores, window and position
  bit [PIX_W-1:0] row_older [MAX_W];
  bit [PIX_W-1:0] row_newer [MAX_W];
  bit [PIX_W-1:0] win_cols [6];
  bit [PIX_W-1:0] rank_pool [9];
  int unsigned    next_col = 0;
  int unsigned    next_row = 0;
  bit             held_pending = 1'b0;
  res_t           held_copy;

  // results of the item being predicted, and every result still owed by the dut
  res_t step_results [$];
  res_t awaited_pixels [$];

  // stimulus knobs
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  px_style_e px_style = PX_FULL;
  bit [PIX_W-1:0] px_band_base = '0;

  // run statistics
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned cfg_writes    = 0;
  int unsigned mismatches    = 0;
  res_t        got_res;
  res_t        want_res;

  median_filter_3x3_3x2_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_in     (in_pixel_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_out   (out_pixel_out),
    .out_column      (out_column),
    .out_row         (out_row),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  // registers as the filter uses them: width clamped to 3..MAX_W, height to at least 3
  function automatic int unsigned active_width();
    int unsigned w;
    w = px_width;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned active_height();
    return (px_height < MIN_DIM) ? MIN_DIM : px_height;
  endfunction

  // fifth smallest of the first n pool entries: the value whose rank range covers 4
  function automatic bit [PIX_W-1:0] fifth_smallest(input int n);
    int below;
    int upto;
    for (int i = 0; i < n; i++) begin
      below = 0;
      upto  = 0;
      for (int j = 0; j < n; j++) begin
        if (rank_pool[j] < rank_pool[i]) below++;
        if (rank_pool[j] <= rank_pool[i]) upto++;
      end
      if (below <= 4 && upto > 4) return rank_pool[i];
    end
    return '0;
  endfunction

  function automatic void add_result(input bit [PIX_W-1:0] px, input int unsigned x,
                                     input int unsigned y);
    res_t item;
    item.pix  = px;
    item.col  = x[COL_W-1:0];
    item.row  = y[ROW_W-1:0];
    item.last = 1'b0;
    step_results.push_back(item);
  endfunction

  // one accepted pixel: advance the predictor and queue the results it causes
  function automatic void compute_filter_outputs(input bit [PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    bit [PIX_W-1:0] up2;
    bit [PIX_W-1:0] up1;
    bit [PIX_W-1:0] m;
    w = active_width();
    h = active_height();
    // a position left over from a larger frame moves on before use
    if (next_col >= w) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= h) next_row = 0;
    c = next_col;
    r = next_row;
    step_results.delete();

    // deferred copy from a width-three frame end goes out first
    if (held_pending) begin
      step_results.push_back(held_copy);
      held_pending = 1'b0;
    end

    up2 = row_older[c];
    up1 = row_newer[c];

    if (px_mode == MODE_3X3) begin
      if (r >= 2 && c >= FIRST_FULL_COL) begin
        for (int i = 0; i < 6; i++) rank_pool[i] = win_cols[i];
        rank_pool[6] = up2;
        rank_pool[7] = up1;
        rank_pool[8] = px;
        m = fifth_smallest(9);
        if (c == FIRST_FULL_COL) add_result(m, 0, r - 1);
        add_result(m, c - 1, r - 1);
        if (c == w - 1) add_result(m, w - 1, r - 1);
      end
      if (r == 0 || r == h - 1) begin
        if (step_results.size() < MAX_RES) begin
          add_result(px, c, r);
        end else begin
          held_pending   = 1'b1;
          held_copy.pix  = px;
          held_copy.col  = c[COL_W-1:0];
          held_copy.row  = r[ROW_W-1:0];
          held_copy.last = 1'b0;
        end
      end
    end else begin
      if (r == 0 || r == h - 1) begin
        add_result(px, c, r);
      end else begin
        if (c == 0) add_result(px, 0, r);
        if (c >= FIRST_FULL_COL) begin
          rank_pool[0] = win_cols[1];
          rank_pool[1] = win_cols[2];
          rank_pool[2] = win_cols[4];
          rank_pool[3] = win_cols[5];
          rank_pool[4] = up1;
          rank_pool[5] = px;
          add_result(fifth_smallest(6), c - 1, r);
        end
        if (c == w - 1) add_result(px, w - 1, r);
      end
    end

    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = up2;
    win_cols[4] = up1;
    win_cols[5] = px;
    row_older[c] = up1;
    row_newer[c] = px;

    next_col = c + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = r + 1;
      if (next_row >= h) next_row = 0;
    end

    if (step_results.size() > 0) step_results[$].last = 1'b1;
    foreach (step_results[i]) awaited_pixels.push_back(step_results[i]);
  endfunction

  // ------------------------------------------------------------------
  // result checking, on every accepted result item
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      got_res.pix  = out_pixel_out;
      got_res.col  = out_column;
      got_res.row  = out_row;
      got_res.last = out_last_of_run;
      if (awaited_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result pix %h col %0d row %0d last %b", $time,
                   got_res.pix, got_res.col, got_res.row, got_res.last);
      end else begin
        want_res = awaited_pixels.pop_front();
        if (got_res !== want_res) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: expected pix %h col %0d row %0d last %b, got pix %h col %0d row %0d last %b",
                     $time, want_res.pix, want_res.col, want_res.row, want_res.last,
                     got_res.pix, got_res.col, got_res.row, got_res.last);
        end
      end
    end
  end

  // run guard: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still owed", $time, cycle_count,
               awaited_pixels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ------------------------------------------------------------------
  // drivers, all called at a falling edge and returning at one
  // ------------------------------------------------------------------

  function automatic void choose_pixel_style();
    case ($urandom_range(0, 3))
      0:       px_style = PX_BAND;
      1:       px_style = PX_EXTREME;
      default: px_style = PX_FULL;
    endcase
    px_band_base = 16'($urandom);
  endfunction

  // banded and extreme styles give plenty of ties inside a window
  function automatic bit [PIX_W-1:0] next_pixel();
    case (px_style)
      PX_BAND:    return px_band_base ^ 16'($urandom_range(0, 3));
      PX_EXTREME: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default:    return 16'($urandom);
    endcase
  endfunction

  // one item on the input channel; valid stays high on return unless idling follows
  task automatic send_pixel(input bit [PIX_W-1:0] px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compute_filter_outputs(px);
    items_sent++;
    @(negedge clk);
  endtask

  // sender holds off until the dut has delivered every owed result
  task automatic hold_until_empty();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited_pixels.size() != 0);
  endtask

  // idle point for register writes: nothing owed and the pipeline flushed
  task automatic wait_drained();
    hold_until_empty();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_pixels(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 63) == 0) hold_until_empty();
      send_pixel(next_pixel());
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  px_width  = val[IMG_W_W-1:0];
      REG_IMAGE_HEIGHT: px_height = val;
      REG_WINDOW_MODE:  px_mode   = val[0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure_frame(input logic [CFG_DATA_W-1:0] w_reg,
                                 input logic [CFG_DATA_W-1:0] h_reg,
                                 input logic [CFG_DATA_W-1:0] mode_reg);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, w_reg);
    write_reg(REG_IMAGE_HEIGHT, h_reg);
    write_reg(REG_WINDOW_MODE, mode_reg);
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // reset registers give a 512 wide 3x3 frame: first items of row 0 are copied
  task automatic test_reset_values();
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h8001);
  endtask

  // width three in 3x3 mode, with masked high bits and a clamped height; the
  // position left at column 3 moves to row 1, and each frame end defers its copy
  task automatic test_narrow_deferred_copy();
    bit [PIX_W-1:0] px_list [15];
    px_list = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF,
                16'h1234, 16'h1234, 16'h1234, 16'h0000, 16'hFFFF, 16'h0000,
                16'hFFFF, 16'h5555, 16'hAAAA};
    wait_drained();
    write_reg(REG_SPARE, 16'h0007);
    write_reg(REG_IMAGE_WIDTH, 16'hE003);
    write_reg(REG_IMAGE_HEIGHT, 16'h0001);
    write_reg(REG_WINDOW_MODE, 16'hAAAA);
    foreach (px_list[i]) send_pixel(px_list[i]);
  endtask

  // 3x2 window on the smallest frame; the first item also releases the deferred copy
  task automatic test_3x2_narrow();
    bit [PIX_W-1:0] px_list [9];
    px_list = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0003, 16'h0003, 16'h0001,
                16'hFFFF, 16'h0002, 16'h0000};
    configure_frame(16'h0000, 16'h0003, 16'h0001);
    foreach (px_list[i]) send_pixel(px_list[i]);
  endtask

  // whole frames with random small geometry, mode and content
  task automatic test_random_frames(input int unsigned target);
    int unsigned sent_here;
    logic [CFG_DATA_W-1:0] w_reg;
    logic [CFG_DATA_W-1:0] h_reg;
    logic [CFG_DATA_W-1:0] mode_reg;
    sent_here = 0;
    while (sent_here < target) begin
      case ($urandom_range(0, 9))
        0:       w_reg = 16'($urandom_range(0, 2));
        1:       w_reg = 16'($urandom_range(3, 12)) | (16'($urandom_range(1, 7)) << 13);
        2:       w_reg = 16'($urandom_range(13, 40));
        default: w_reg = 16'($urandom_range(3, 12));
      endcase
      h_reg = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(7, 9))
                                          : 16'($urandom_range(0, 6));
      mode_reg = {15'($urandom_range(0, 32767)), 1'($urandom_range(0, 1))};
      configure_frame(w_reg, h_reg, mode_reg);
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 16'($urandom));
      repeat ($urandom_range(1, 2)) begin
        choose_pixel_style();
        send_pixels(active_width() * active_height());
        sent_here += active_width() * active_height();
      end
    end
  endtask

  // registers shrunk in mid frame: a column beyond the new width starts the next
  // row, a row beyond the new height starts a new frame
  task automatic test_mid_frame_shrink();
    logic [CFG_DATA_W-1:0] mode_reg;
    mode_reg = 16'($urandom_range(0, 1));
    configure_frame(16'($urandom_range(8, 12)), 16'h0006, mode_reg);
    choose_pixel_style();
    send_pixels(2 * active_width() + 5);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 16'h0004);
    send_pixels(3 * 4);

    configure_frame(16'h0005, 16'h0009, mode_reg ^ 16'h0001);
    send_pixels(6 * 5);
    wait_drained();
    write_reg(REG_IMAGE_HEIGHT, 16'h0004);
    send_pixels(5 * 4);
  endtask

  // all-ones width register clamps to the full line store, height zero clamps to 3
  task automatic test_full_width_frame();
    configure_frame(16'hFFFF, 16'h0000, {15'($urandom_range(0, 32767)), 1'($urandom_range(0, 1))});
    for (int rr = 0; rr < MIN_DIM; rr++) begin
      choose_pixel_style();
      send_pixels(active_width());
    end
  endtask

  // tallest frame, only its first rows are streamed
  task automatic test_tall_frame_tail();
    configure_frame(16'h0005, 16'hFFFF, 16'($urandom_range(0, 1)));
    choose_pixel_style();
    send_pixels(5 * 4);
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------
  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 11;
    recv_idle_pct = 70;
    test_reset_values();
    test_narrow_deferred_copy();
    test_3x2_narrow();
    test_random_frames(100);

    // the other way round
    send_idle_pct = 70;
    recv_idle_pct = 11;
    test_mid_frame_shrink();
    test_random_frames(100);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(100);
    test_full_width_frame();
    test_tall_frame_tail();

    wait_drained();
    $display("covered %0d pixel items and %0d result items over %0d register writes,",
             items_sent, results_seen, cfg_writes);
    $display("both window modes, widths 3 to 4096, mid-frame shrinks and deferred copies");
    if (mismatches == 0 && awaited_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
